FILE: sv/pai_pkg.sv
`default_nettype none

package pai_pkg;

  // Compare periods of the two timers
  localparam int unsigned BRAKE_PERIOD = 3500;
  localparam int unsigned PHASE_PERIOD = 3500;

  localparam int unsigned TIME_W = 16;

  // Reset and safe-state compare values
  localparam logic [TIME_W-1:0] PHASE_RESET      = TIME_W'(PHASE_PERIOD / 2);
  localparam logic [TIME_W-1:0] BRAKE_LOW_SAFE   = '0;
  localparam logic [TIME_W-1:0] BRAKE_HIGH_SAFE  = TIME_W'(BRAKE_PERIOD + 1);
  localparam logic [TIME_W-1:0] DEADTIME_RESET   = TIME_W'(20);

  // Stream widths
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic [2:0] {
    OP_ARM_BRAKE    = 3'd0,
    OP_DISARM_BRAKE = 3'd1,
    OP_ARM_MOTOR    = 3'd2,
    OP_DISARM_MOTOR = 3'd3,
    OP_APPLY_PHASE  = 3'd4,
    OP_APPLY_BRAKE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DISARMED     = 2'd0,
    ST_WAIT_TIMINGS = 2'd1,
    ST_WAIT_UPDATE  = 2'd2,
    ST_ARMED        = 2'd3
  } arm_state_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [TIME_W-1:0] phase_a_time;
    logic [TIME_W-1:0] phase_b_time;
    logic [TIME_W-1:0] phase_c_time;
    logic [TIME_W-1:0] brake_low_off;
    logic [TIME_W-1:0] brake_high_on;
  } cmd_t;

  typedef struct packed {
    logic              outputs_enabled;
    arm_state_t        arm_state;
    logic              brake_is_armed;
    logic              prior_armed;
    logic [TIME_W-1:0] phase_a_compare;
    logic [TIME_W-1:0] phase_b_compare;
    logic [TIME_W-1:0] phase_c_compare;
    logic [TIME_W-1:0] brake_low_compare;
    logic [TIME_W-1:0] brake_high_compare;
    logic              fault_latched;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/pai_in_stage.sv
`default_nettype none

module pai_in_stage
  import pai_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_USER_W-1:0] s_tuser,
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  input  wire logic                 take,
  output logic                      cmd_valid,
  output cmd_t                      cmd
);

  // Accept when empty or when the held command leaves this cycle
  assign s_tready = !cmd_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd.op            <= s_tuser;
      cmd.phase_a_time  <= s_tdata[15:0];
      cmd.phase_b_time  <= s_tdata[31:16];
      cmd.phase_c_time  <= s_tdata[47:32];
      cmd.brake_low_off <= s_tdata[63:48];
      cmd.brake_high_on <= s_tdata[79:64];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pai_core.sv
`default_nettype none

module pai_core
  import pai_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata,
  input  wire logic              fire,
  input  cmd_t                   cmd,
  output result_t                res
);

  logic [TIME_W-1:0] deadtime_clocks;
  logic              brake_armed;
  arm_state_t        motor_arm_state;
  logic              output_enable;
  logic [TIME_W-1:0] phase_a, phase_b, phase_c;
  logic [TIME_W-1:0] brake_low_reg, brake_high_reg;
  logic              fault_flag;

  logic              brake_armed_next;
  arm_state_t        motor_arm_state_next;
  logic              output_enable_next;
  logic [TIME_W-1:0] phase_a_next, phase_b_next, phase_c_next;
  logic [TIME_W-1:0] brake_low_next, brake_high_next;
  logic              fault_next;
  logic              was;
  logic              gap_fault;
  logic [TIME_W-1:0] gap;

  // Brake gap; a wrapping gap never faults
  assign gap       = cmd.brake_high_on - cmd.brake_low_off;
  assign gap_fault = (cmd.brake_high_on >= cmd.brake_low_off) && (gap < deadtime_clocks);

  // Work out the interlock state after the command
  always_comb begin
    brake_armed_next     = brake_armed;
    motor_arm_state_next = motor_arm_state;
    output_enable_next   = output_enable;
    phase_a_next         = phase_a;
    phase_b_next         = phase_b;
    phase_c_next         = phase_c;
    brake_low_next       = brake_low_reg;
    brake_high_next      = brake_high_reg;
    fault_next           = fault_flag;
    was                  = 1'b0;
    case (cmd.op)
      OP_ARM_BRAKE: begin
        brake_armed_next = 1'b1;
        brake_low_next   = BRAKE_LOW_SAFE;
        brake_high_next  = BRAKE_HIGH_SAFE;
      end
      OP_DISARM_BRAKE: begin
        brake_armed_next     = 1'b0;
        brake_low_next       = BRAKE_LOW_SAFE;
        brake_high_next      = BRAKE_HIGH_SAFE;
        motor_arm_state_next = ST_DISARMED;
        output_enable_next   = 1'b0;
      end
      OP_ARM_MOTOR: begin
        if (brake_armed) begin
          motor_arm_state_next = ST_WAIT_TIMINGS;
        end
      end
      OP_DISARM_MOTOR: begin
        was                  = (motor_arm_state != ST_DISARMED);
        motor_arm_state_next = ST_DISARMED;
        output_enable_next   = 1'b0;
      end
      OP_APPLY_PHASE: begin
        phase_a_next = cmd.phase_a_time;
        phase_b_next = cmd.phase_b_time;
        phase_c_next = cmd.phase_c_time;
        if (!brake_armed) begin
          motor_arm_state_next = ST_DISARMED;
          output_enable_next   = 1'b0;
        end else begin
          case (motor_arm_state)
            ST_WAIT_TIMINGS: motor_arm_state_next = ST_WAIT_UPDATE;
            ST_WAIT_UPDATE: begin
              motor_arm_state_next = ST_ARMED;
              output_enable_next   = 1'b1;
            end
            ST_ARMED: motor_arm_state_next = ST_ARMED;
            default: begin
              motor_arm_state_next = ST_DISARMED;
              output_enable_next   = 1'b0;
            end
          endcase
        end
      end
      OP_APPLY_BRAKE: begin
        if (gap_fault) begin
          fault_next           = 1'b1;
          brake_armed_next     = 1'b0;
          brake_low_next       = BRAKE_LOW_SAFE;
          brake_high_next      = BRAKE_HIGH_SAFE;
          motor_arm_state_next = ST_DISARMED;
          output_enable_next   = 1'b0;
        end else if (brake_armed) begin
          brake_low_next  = cmd.brake_low_off;
          brake_high_next = cmd.brake_high_on;
        end
      end
      default: begin
        was = 1'b0;
      end
    endcase
  end

  // Hold the deadtime register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadtime_clocks <= DEADTIME_RESET;
    end else if (cfg_we) begin
      deadtime_clocks <= cfg_wdata;
    end
  end

  // Advance the interlock state on each command
  always_ff @(posedge clk) begin
    if (rst) begin
      brake_armed     <= 1'b0;
      motor_arm_state <= ST_DISARMED;
      output_enable   <= 1'b0;
      phase_a         <= PHASE_RESET;
      phase_b         <= PHASE_RESET;
      phase_c         <= PHASE_RESET;
      brake_low_reg   <= BRAKE_LOW_SAFE;
      brake_high_reg  <= BRAKE_HIGH_SAFE;
      fault_flag      <= 1'b0;
    end else if (fire) begin
      brake_armed     <= brake_armed_next;
      motor_arm_state <= motor_arm_state_next;
      output_enable   <= output_enable_next;
      phase_a         <= phase_a_next;
      phase_b         <= phase_b_next;
      phase_c         <= phase_c_next;
      brake_low_reg   <= brake_low_next;
      brake_high_reg  <= brake_high_next;
      fault_flag      <= fault_next;
    end
  end

  // Result shows the state after the command
  always_comb begin
    res.outputs_enabled    = output_enable_next;
    res.arm_state          = motor_arm_state_next;
    res.brake_is_armed     = brake_armed_next;
    res.prior_armed        = was;
    res.phase_a_compare    = phase_a_next;
    res.phase_b_compare    = phase_b_next;
    res.phase_c_compare    = phase_c_next;
    res.brake_low_compare  = brake_low_next;
    res.brake_high_compare = brake_high_next;
    res.fault_latched      = fault_next;
  end

  a_oe_needs_brake: assert property (@(posedge clk) disable iff (rst)
    output_enable |-> brake_armed)
    else $error("outputs enabled with brake disarmed");

  a_motor_needs_brake: assert property (@(posedge clk) disable iff (rst)
    (motor_arm_state != ST_DISARMED) |-> brake_armed)
    else $error("motor armed with brake disarmed");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("fault flag cleared without reset");

  a_fault_safe: assert property (@(posedge clk) disable iff (rst)
    (fire && (cmd.op == OP_APPLY_BRAKE) && gap_fault) |=>
      (!brake_armed && !output_enable && brake_low_reg == BRAKE_LOW_SAFE
       && brake_high_reg == BRAKE_HIGH_SAFE))
    else $error("deadtime fault left brake or motor armed");

endmodule

`default_nettype wire

FILE: sv/pai_out_stage.sv
`default_nettype none

module pai_out_stage
  import pai_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  result_t                    res,
  output logic                       free,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  result_t held;

  // Room for a new result when empty or the held one is taken now
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= res;
    end
  end

  // Pack fields from the lowest bit up, zero fill to whole bytes
  assign m_tdata = {2'b00,
                    held.fault_latched,
                    held.brake_high_compare,
                    held.brake_low_compare,
                    held.phase_c_compare,
                    held.phase_b_compare,
                    held.phase_a_compare,
                    held.prior_armed,
                    held.brake_is_armed,
                    held.arm_state,
                    held.outputs_enabled};

endmodule

`default_nettype wire

FILE: sv/pwm_arming_interlock.sv
// Channel   | Signals                          | Contents
// s (in)    | s_tvalid s_tready s_tuser s_tdata | one command
// m (out)   | m_tvalid m_tready m_tdata         | interlock status after command
// cfg       | cfg_we cfg_wdata                  | deadtime_clocks
//
// One command a cycle sustained while m_tready is high; input and result are both registered.
// The state update is one combinational pass between input and result registers.
// rst is synchronous: brake and motor disarmed, compares at their reset values,
// deadtime 20, fault clear, both stages empty.
// A stalled output holds its result; the input keeps taking commands while a
// stage is free.
`default_nettype none

module pwm_arming_interlock
  import pai_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // op
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // phase_a_time, phase_b_time, phase_c_time,
                                                 // brake_low_off, brake_high_on
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // outputs_enabled, arm_state, brake_is_armed,
                                                 // prior_armed, phase_a/b/c_compare,
                                                 // brake_low/high_compare, fault_latched, pad
  input  wire logic                  cfg_we,
  input  wire logic [TIME_W-1:0]     cfg_wdata
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    free;
  logic    fire;
  result_t res;

  assign fire = cmd_valid && free;

  pai_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .take      (fire),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  pai_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .cmd       (cmd),
    .res       (res)
  );

  pai_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd_valid),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import pai_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_GUARD = 5000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_USER_W-1:0]  s_tuser;   // op
  logic [IN_DATA_W-1:0]  s_tdata;   // phase_a_time, phase_b_time, phase_c_time,
                                    // brake_low_off, brake_high_on
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // outputs_enabled, arm_state, brake_is_armed, prior_armed,
                                    // phase_a/b/c_compare, brake_low/high_compare,
                                    // fault_latched, pad
  logic                  cfg_we;
  logic [TIME_W-1:0]     cfg_wdata;

  // Shadow of the interlock state
  logic              brk_armed;
  arm_state_t        motor_state;
  logic              pwm_enable;
  logic [TIME_W-1:0] phase_cmp [3];
  logic [TIME_W-1:0] brk_lo_cmp;
  logic [TIME_W-1:0] brk_hi_cmp;
  logic              fault_seen;
  logic [TIME_W-1:0] deadtime;

  result_t status_expected [$];
  int      mismatch_count;
  int      cycle_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  pwm_arming_interlock uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drop the motor to disarmed with outputs off
  function automatic void drop_motor();
    motor_state = ST_DISARMED;
    pwm_enable  = 1'b0;
  endfunction

  // Drop the brake, park its compares and disarm the motor
  function automatic void drop_brake();
    brk_armed  = 1'b0;
    brk_lo_cmp = BRAKE_LOW_SAFE;
    brk_hi_cmp = BRAKE_HIGH_SAFE;
    drop_motor();
  endfunction

  // Advance the shadow state by one command and return the status it shows
  function automatic result_t interlock_next(logic [2:0] op, logic [IN_DATA_W-1:0] data);
    result_t           r;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic              was;
    was = 1'b0;
    lo  = data[63:48];
    hi  = data[79:64];
    case (op)
      OP_ARM_BRAKE: begin
        brk_armed  = 1'b1;
        brk_lo_cmp = BRAKE_LOW_SAFE;
        brk_hi_cmp = BRAKE_HIGH_SAFE;
      end
      OP_DISARM_BRAKE: drop_brake();
      OP_ARM_MOTOR: begin
        if (brk_armed) motor_state = ST_WAIT_TIMINGS;
      end
      OP_DISARM_MOTOR: begin
        was = (motor_state != ST_DISARMED);
        drop_motor();
      end
      OP_APPLY_PHASE: begin
        if (!brk_armed) motor_state = ST_DISARMED;
        phase_cmp[0] = data[15:0];
        phase_cmp[1] = data[31:16];
        phase_cmp[2] = data[47:32];
        case (motor_state)
          ST_WAIT_TIMINGS: motor_state = ST_WAIT_UPDATE;
          ST_WAIT_UPDATE: begin
            motor_state = ST_ARMED;
            pwm_enable  = 1'b1;
          end
          ST_ARMED: ;
          default: drop_motor();
        endcase
      end
      OP_APPLY_BRAKE: begin
        // a gap that wraps below zero is huge and never trips
        if (hi >= lo && (hi - lo) < deadtime) begin
          fault_seen = 1'b1;
          drop_brake();
        end
        if (brk_armed) begin
          brk_lo_cmp = lo;
          brk_hi_cmp = hi;
        end
      end
      default: ;
    endcase
    r.outputs_enabled    = pwm_enable;
    r.arm_state          = motor_state;
    r.brake_is_armed     = brk_armed;
    r.prior_armed        = was;
    r.phase_a_compare    = phase_cmp[0];
    r.phase_b_compare    = phase_cmp[1];
    r.phase_c_compare    = phase_cmp[2];
    r.brake_low_compare  = brk_lo_cmp;
    r.brake_high_compare = brk_hi_cmp;
    r.fault_latched      = fault_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, exp, act);
    end
  endfunction

  // Check each output transaction against the oldest expected status
  always @(posedge clk) begin
    result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      if (status_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected status transaction %h", m_tdata);
      end else begin
        exp = status_expected.pop_front();
        check_field("outputs_enabled", 16'(exp.outputs_enabled), 16'(m_tdata[0]));
        check_field("arm_state", 16'(exp.arm_state), 16'(m_tdata[2:1]));
        check_field("brake_is_armed", 16'(exp.brake_is_armed), 16'(m_tdata[3]));
        check_field("prior_armed", 16'(exp.prior_armed), 16'(m_tdata[4]));
        check_field("phase_a_compare", exp.phase_a_compare, m_tdata[20:5]);
        check_field("phase_b_compare", exp.phase_b_compare, m_tdata[36:21]);
        check_field("phase_c_compare", exp.phase_c_compare, m_tdata[52:37]);
        check_field("brake_low_compare", exp.brake_low_compare, m_tdata[68:53]);
        check_field("brake_high_compare", exp.brake_high_compare, m_tdata[84:69]);
        check_field("fault_latched", 16'(exp.fault_latched), 16'(m_tdata[85]));
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pwm_arming_interlock verification failed");
      $finish;
    end
  end

  // Stall the output side at random
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one command and hold it until the transaction completes
  task automatic send_command(logic [2:0] op, logic [IN_DATA_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    status_expected.push_back(interlock_next(op, data));
  endtask

  function automatic logic [IN_DATA_W-1:0] phase_data(logic [15:0] a, logic [15:0] b,
                                                      logic [15:0] c);
    return {32'h0, c, b, a};
  endfunction

  function automatic logic [IN_DATA_W-1:0] brake_data(logic [15:0] lo, logic [15:0] hi);
    return {hi, lo, 48'h0};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_data();
    logic [IN_DATA_W-1:0] d;
    d[31:0]  = $urandom;
    d[63:32] = $urandom;
    d[79:64] = 16'($urandom_range(0, 65535));
    return d;
  endfunction

  // Brake timings whose gap clears the deadtime, wrapping now and then
  function automatic logic [IN_DATA_W-1:0] clean_brake_data();
    logic [15:0] lo;
    logic [17:0] hi;
    lo = 16'($urandom_range(0, 65535));
    hi = 18'(lo + deadtime + $urandom_range(0, 300));
    return {hi[15:0], lo, 16'($urandom), 32'($urandom)};
  endfunction

  // Hold off the sender until every status has come back
  task automatic wait_drain();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (status_expected.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_deadtime(logic [TIME_W-1:0] value);
    wait_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    deadtime  = value;
  endtask

  task automatic test_arming_sequence();
    send_command(OP_SPARE_LO, random_data());
    send_command(OP_ARM_MOTOR, random_data());
    send_command(OP_APPLY_PHASE, phase_data(16'hFFFF, 16'h0000, 16'hAAAA));
    send_command(OP_ARM_BRAKE, random_data());
    send_command(OP_ARM_MOTOR, random_data());
    send_command(OP_APPLY_PHASE, phase_data(16'h0000, 16'hFFFF, 16'h5555));
    send_command(OP_APPLY_PHASE, phase_data(16'h1234, 16'h8000, 16'h7FFF));
    // re-arming while armed restarts the sequence but keeps outputs on
    send_command(OP_ARM_MOTOR, random_data());
    send_command(OP_APPLY_PHASE, random_data());
    wait_drain();
    send_command(OP_DISARM_MOTOR, random_data());
    send_command(OP_DISARM_MOTOR, random_data());
    send_command(OP_ARM_MOTOR, random_data());
    send_command(OP_DISARM_BRAKE, random_data());
    send_command(OP_APPLY_PHASE, random_data());
  endtask

  task automatic test_brake_timings();
    send_command(OP_APPLY_BRAKE, brake_data(16'h0000, 16'h1000));
    send_command(OP_ARM_BRAKE, random_data());
    send_command(OP_APPLY_BRAKE, brake_data(16'h0000, 16'hFFFF));
    send_command(OP_APPLY_BRAKE, brake_data(16'hFFFF, 16'h0000));
    send_command(OP_APPLY_BRAKE, brake_data(16'd100, 16'd120));
    send_command(OP_SPARE_HI, random_data());
    send_command(OP_ARM_MOTOR, random_data());
    // gap one short of the deadtime trips the fault
    send_command(OP_APPLY_BRAKE, brake_data(16'd200, 16'd219));
    send_command(OP_ARM_BRAKE, random_data());
  endtask

  task automatic test_deadtime_extremes();
    set_deadtime(16'h0000);
    send_command(OP_APPLY_BRAKE, brake_data(16'h8000, 16'h8000));
    set_deadtime(16'hFFFF);
    send_command(OP_APPLY_BRAKE, brake_data(16'h0000, 16'hFFFF));
    send_command(OP_APPLY_BRAKE, brake_data(16'h0001, 16'hFFFF));
  endtask

  // Arm the brake and walk the motor toward armed with random timings
  task automatic send_arming_run();
    int steps;
    steps = $urandom_range(1, 4);
    send_command(OP_ARM_BRAKE, random_data());
    send_command(OP_APPLY_BRAKE, clean_brake_data());
    send_command(OP_ARM_MOTOR, random_data());
    repeat (steps) send_command(OP_APPLY_PHASE, random_data());
  endtask

  task automatic send_random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      send_command(OP_ARM_BRAKE, random_data());
    else if (pick < 13) send_command(OP_DISARM_BRAKE, random_data());
    else if (pick < 25) send_command(OP_ARM_MOTOR, random_data());
    else if (pick < 32) send_command(OP_DISARM_MOTOR, random_data());
    else if (pick < 62) send_command(OP_APPLY_PHASE, random_data());
    else if (pick < 82) send_command(OP_APPLY_BRAKE, clean_brake_data());
    else if (pick < 87) send_command(OP_APPLY_BRAKE, random_data());
    else if (pick < 90) send_command(OP_APPLY_BRAKE,
                                     brake_data(16'd1000, 16'(1000 + $urandom_range(0, 40))));
    else if (pick < 95) send_command(OP_ARM_BRAKE, random_data());
    else                send_command($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
                                     random_data());
  endtask

  task automatic test_random_traffic(int count, int s_idle, int r_idle);
    int sent;
    sent = 0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 20) begin
        send_arming_run();
        sent += 5;
      end else begin
        send_random_command();
        sent++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tuser        = '0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 54;
    brk_armed      = 1'b0;
    motor_state    = ST_DISARMED;
    pwm_enable     = 1'b0;
    phase_cmp[0]   = PHASE_RESET;
    phase_cmp[1]   = PHASE_RESET;
    phase_cmp[2]   = PHASE_RESET;
    brk_lo_cmp     = BRAKE_LOW_SAFE;
    brk_hi_cmp     = BRAKE_HIGH_SAFE;
    fault_seen     = 1'b0;
    deadtime       = DEADTIME_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_arming_sequence();
    test_brake_timings();
    test_deadtime_extremes();

    set_deadtime(16'h0000);
    test_random_traffic(700, 34, 54);
    set_deadtime(16'($urandom_range(1, 500)));
    test_random_traffic(700, 54, 34);
    set_deadtime(DEADTIME_RESET);
    test_random_traffic(600, 0, 0);

    wait_drain();
    repeat (10) @(posedge clk);
    if (status_expected.size() != 0) begin
      mismatch_count++;
      $display("%0d expected status transactions never arrived", status_expected.size());
    end
    if (mismatch_count == 0) begin
      $display("pwm_arming_interlock verification clean");
    end else begin
      $display("pwm_arming_interlock verification failed");
    end
    $finish;
  end

endmodule
